@@ design/ipd_pkg.sv @@
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants of the isolated pixel detector
// Pixel and window types, register indexes, neighbor enables and the
// L1 color distance used by the judge.
// ----------------------------------------------------------------------------
package ipd_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    // Item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Register widths and limits
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int THRESH_W    = 10;
    localparam int MAX_HEIGHT  = 4096;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd32;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // 3x3 window, cell index = row * 3 + column, center at 4
    typedef pixel_t [8:0] window_t;

    // Which sides of the center lie inside the frame
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } nbr_ok_t;

    function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    function automatic logic [9:0] l1_dist(pixel_t a, pixel_t b);
        logic [9:0] d;
        d = {2'b00, abs_diff(a.red, b.red)}
          + {2'b00, abs_diff(a.green, b.green)}
          + {2'b00, abs_diff(a.blue, b.blue)};
        return d;
    endfunction

endpackage

@@ design/ipd_line_buf.sv @@
// ----------------------------------------------------------------------------
// ipd_line_buf: upper and middle line stores
// Reads both rows at one column per item with registered read data. The
// middle row takes the new pixel at once; the upper row takes the old
// middle value in a later, delayed write, with a bypass for a read at that column.
// ----------------------------------------------------------------------------
module ipd_line_buf
    import ipd_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  pixel_t        mid_wdata,
    input  logic          up_wr_en,
    input  logic [AW-1:0] up_wr_addr,
    input  pixel_t        up_wdata,
    output pixel_t        top,
    output pixel_t        mid
);

    pixel_t upper_mem [DEPTH];
    pixel_t middle_mem [DEPTH];
    pixel_t top_reg;
    pixel_t mid_reg;

    // Upper row: delayed write of the old middle value
    always_ff @(posedge clk)
    begin
        if (up_wr_en)
        begin
            upper_mem[up_wr_addr] <= up_wdata;
        end
    end

    // Upper row read, forward a write to the same column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (up_wr_en && (up_wr_addr == rd_addr))
            begin
                top_reg <= up_wdata;
            end
            else
            begin
                top_reg <= upper_mem[rd_addr];
            end
        end
    end

    // Middle row: read old value, write new pixel
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mid_reg             <= middle_mem[rd_addr];
            middle_mem[rd_addr] <= mid_wdata;
        end
    end

    assign top = top_reg;
    assign mid = mid_reg;

endmodule

@@ design/ipd_judge.sv @@
// ----------------------------------------------------------------------------
// ipd_judge: outlier decision for one 3x3 window
// Compares the center with each in-frame neighbor by L1 color distance;
// the center is an outlier when no neighbor is closer than the threshold.
// ----------------------------------------------------------------------------
module ipd_judge
    import ipd_pkg::*;
(
    input  window_t               win,
    input  nbr_ok_t               ok,
    input  logic [THRESH_W-1:0]   threshold,
    output logic                  is_outlier
);

    logic [8:0] nbr_en;
    logic [8:0] close;

    // Enable neighbors inside the frame, never the center
    always_comb
    begin
        nbr_en[0] = ok.top    && ok.left;
        nbr_en[1] = ok.top;
        nbr_en[2] = ok.top    && ok.right;
        nbr_en[3] = ok.left;
        nbr_en[4] = 1'b0;
        nbr_en[5] = ok.right;
        nbr_en[6] = ok.bottom && ok.left;
        nbr_en[7] = ok.bottom;
        nbr_en[8] = ok.bottom && ok.right;
    end

    // Eight distances in parallel
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            close[k] = nbr_en[k] && (l1_dist(win[k], win[4]) < threshold);
        end
    end

    assign is_outlier = ~|close;

endmodule

@@ design/isolated_pixel_detector.sv @@
// ----------------------------------------------------------------------------
// isolated_pixel_detector: 3x3 isolated pixel detector on an RGB stream
// Takes pixels in raster order and reports, for every pixel of the frame,
// whether none of its in-frame neighbors is similar in color.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): op, red, green, blue. Pixels of a
//   frame arrive in raster order; after the last pixel, send flush items
//   (op = 1) to push out the remaining centers: width + 1 of them, the last
//   result carrying frame_last. A flush before the frame end is accepted and
//   dropped; a pixel after the frame end acts as a flush.
//   Output channel (out_valid/out_ready): center_col, center_row,
//   is_outlier, frame_last. Each item judges the center one row and one
//   pixel behind it, so the first row and a pixel of a frame give no result.
//   Throughput: one item per cycle while the receiver takes results.
//   A result is valid once its item has passed the line store read
//   register (loaded at acceptance) and then the result register. When
//   the receiver stalls, the result register holds and the input keeps
//   accepting until the one internal stage is full.
//   Configuration: write only while idle. Writing width or height restarts
//   the frame position; line stores and window keep their contents.
//   Reset: registers take width 640, height 480, threshold 32, position
//   zero, window cleared. Line stores are not cleared; no start-up pass.
// ----------------------------------------------------------------------------
module isolated_pixel_detector
    import ipd_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input items
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    // Result items
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [9:0]            center_col,
    output logic [11:0]           center_row,
    output logic                  is_outlier,
    output logic                  frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // Configuration registers
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [THRESH_W-1:0] thresh_reg;

    // Frame position
    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;

    // Stage 1 (line store read data aligned with these)
    logic                s1_valid_reg;
    pixel_t              s1_pix_reg;
    logic [COL_W-1:0]    s1_addr_reg;
    logic                s1_has_res_reg;
    logic [9:0]          s1_col_reg;
    logic [11:0]         s1_row_reg;
    logic                s1_last_reg;
    nbr_ok_t             s1_ok_reg;

    // Window and output
    window_t             window_reg;
    window_t             window_next;
    logic                out_valid_reg;
    logic [9:0]          center_col_reg;
    logic [11:0]         center_row_reg;
    logic                is_outlier_reg;
    logic                frame_last_reg;

    // Stage 0 signals
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [WIDTH_W-1:0]  col_w;
    logic                flushing;
    logic                accept;
    logic                process;
    logic                has_center;
    logic [HEIGHT_W-1:0] cr;
    logic [WIDTH_W-1:0]  cc;
    logic                last;
    nbr_ok_t             ok;
    pixel_t              pix_in;
    logic                s1_advance;
    logic                geom_wr;
    pixel_t              lb_top;
    pixel_t              lb_mid;
    logic                judge_outlier;

    // Effective frame size: zero counts as one, saturate at the maximum
    always_comb
    begin
        priority if (width_reg == '0)
        begin
            w_eff = 11'd1;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end

        priority if (height_reg == '0)
        begin
            h_eff = 13'd1;
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // Handshake: one stage ahead of the result register
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;
    assign flushing   = (row_reg >= h_eff);
    assign process    = accept && !((op == OP_FLUSH) && !flushing);
    assign pix_in     = flushing ? pixel_t'('0) : pixel_t'({red, green, blue});
    assign col_w      = WIDTH_W'(col_reg);
    assign geom_wr    = cfg_wr_en
                        && ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

    // Locate the center judged by this item and its in-frame sides
    always_comb
    begin
        if (col_reg != '0)
        begin
            has_center = (row_reg != '0) && ((row_reg - 13'd1) < h_eff);
            cr         = row_reg - 13'd1;
            cc         = col_w - 11'd1;
        end
        else
        begin
            has_center = (row_reg >= 13'd2) && ((row_reg - 13'd2) < h_eff);
            cr         = row_reg - 13'd2;
            cc         = w_eff - 11'd1;
        end
        last      = has_center && (cr == h_eff - 13'd1) && (cc == w_eff - 11'd1);
        ok.top    = (cr != '0);
        ok.bottom = (cr != h_eff - 13'd1);
        ok.left   = (cc != '0);
        ok.right  = (cc != w_eff - 11'd1);
    end

    // Advance the frame position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (process)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_w >= w_eff - 11'd1)
            begin
                col_next = '0;
                row_next = row_reg + 13'd1;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Configuration registers and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thresh_reg <= THRESH_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                    REG_FRAME_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                    REG_THRESHOLD:    thresh_reg <= cfg_data[THRESH_W-1:0];
                    default:          ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line stores
    ipd_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_buf (
        .clk        (clk),
        .rd_en      (process),
        .rd_addr    (col_reg),
        .mid_wdata  (pix_in),
        .up_wr_en   (s1_advance),
        .up_wr_addr (s1_addr_reg),
        .up_wdata   (lb_mid),
        .top        (lb_top),
        .mid        (lb_mid)
    );

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= process;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            s1_pix_reg     <= pix_in;
            s1_addr_reg    <= col_reg;
            s1_has_res_reg <= has_center;
            s1_col_reg     <= 10'(cc);
            s1_row_reg     <= 12'(cr);
            s1_last_reg    <= last;
            s1_ok_reg      <= ok;
        end
    end

    // Shift the window left and insert the new column
    always_comb
    begin
        window_next    = window_reg;
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[2] = lb_top;
        window_next[5] = lb_mid;
        window_next[8] = s1_pix_reg;
    end

    ipd_judge u_judge (
        .win        (window_next),
        .ok         (s1_ok_reg),
        .threshold  (thresh_reg),
        .is_outlier (judge_outlier)
    );

    // Window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (s1_advance)
        begin
            window_reg <= window_next;
        end
    end

    // Result valid: load on a center, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_has_res_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_has_res_reg)
        begin
            center_col_reg <= s1_col_reg;
            center_row_reg <= s1_row_reg;
            is_outlier_reg <= judge_outlier;
            frame_last_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign center_col = center_col_reg;
    assign center_row = center_row_reg;
    assign is_outlier = is_outlier_reg;
    assign frame_last = frame_last_reg;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the isolated pixel detector
// Streams RGB frames of many sizes and thresholds, with dropped early flushes,
// pixels that arrive during the flush, frames cut short by a geometry change
// and random stalls on both channels. An item-level predictor of the line
// stores and 3x3 window works out each verdict, and the monitor compares
// every result item, field by field, with the oldest expected verdict.
// ----------------------------------------------------------------------------
module testbench;
    import ipd_pkg::*;

    localparam int LINE_DEPTH   = 1024;
    localparam int RANDOM_ITEMS = 500;
    localparam int WIDE_ITEMS   = LINE_DEPTH + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 100;

    typedef struct {
        logic   op;
        pixel_t px;
        bit     rush;
        bit     hold;
    } feed_item_t;

    typedef struct {
        logic [9:0]  col;
        logic [11:0] row;
        logic        outlier;
        logic        last;
    } verdict_t;

    // DUT signals
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  op = OP_PIXEL;
    logic [7:0]            red = '0;
    logic [7:0]            green = '0;
    logic [7:0]            blue = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [9:0]            center_col;
    logic [11:0]           center_row;
    logic                  is_outlier;
    logic                  frame_last;

    // Stimulus and expectation stores
    feed_item_t pixel_feed[$];
    verdict_t   pending_verdicts[$];
    int         mismatches = 0;
    int         random_items = 0;
    int         cycles = 0;
    bit         item_taken = 1'b0;
    bit         rush_mode = 1'b0;
    bit         hold_request = 1'b0;
    int         feed_gap = 0;
    int         ready_stall = 0;

    // Predictor state
    logic [WIDTH_W-1:0]  cur_width = WIDTH_RESET;
    logic [HEIGHT_W-1:0] cur_height = HEIGHT_RESET;
    logic [THRESH_W-1:0] cur_thresh = THRESH_RESET;
    pixel_t              upper_line [LINE_DEPTH] = '{default: '0};
    pixel_t              middle_line [LINE_DEPTH] = '{default: '0};
    pixel_t              win_cells [9] = '{default: '0};
    logic [9:0]          col_pos = '0;
    logic [12:0]         row_pos = '0;

    isolated_pixel_detector #(
        .MAX_WIDTH (LINE_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .center_col (center_col),
        .center_row (center_row),
        .is_outlier (is_outlier),
        .frame_last (frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int eff_width();
        int w;
        w = cur_width;
        if (w == 0)
            w = 1;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = cur_height;
        if (h == 0)
            h = 1;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic int chan_gap(logic [7:0] a, logic [7:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic bit close_colors(pixel_t a, pixel_t b);
        int d;
        d = chan_gap(a.red, b.red) + chan_gap(a.green, b.green)
          + chan_gap(a.blue, b.blue);
        return d < int'(cur_thresh);
    endfunction

    // Advance the line stores and window by one item; queue its verdict
    task automatic judge_item(input logic item_op, input pixel_t px);
        int       w, h, r, c, cr, cc, nr, nc, i, j, k;
        bit       flushing, alone, at_end;
        pixel_t   pin, top, mid;
        verdict_t v;
        w = eff_width();
        h = eff_height();
        r = row_pos;
        c = col_pos;
        flushing = (r >= h);
        // drop a flush that comes before the frame is complete
        if (item_op == OP_FLUSH && !flushing)
            return;
        if (c >= w)
            c = w - 1;
        // past the last row every item is a blank flush pixel
        pin = flushing ? pixel_t'('0) : px;
        top = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = pin;
        for (k = 0; k < 3; k++)
        begin
            win_cells[k * 3]     = win_cells[k * 3 + 1];
            win_cells[k * 3 + 1] = win_cells[k * 3 + 2];
        end
        win_cells[2] = top;
        win_cells[5] = mid;
        win_cells[8] = pin;
        // the center trails the item by one row and one pixel
        if (c >= 1)
        begin
            cr = r - 1;
            cc = c - 1;
        end
        else
        begin
            cr = r - 2;
            cc = w - 1;
        end
        at_end = 1'b0;
        if (cr >= 0 && cr < h)
        begin
            alone = 1'b1;
            for (i = 0; i < 3; i++)
            begin
                for (j = 0; j < 3; j++)
                begin
                    nr = cr - 1 + i;
                    nc = cc - 1 + j;
                    if (!(i == 1 && j == 1) && nr >= 0 && nr < h && nc >= 0 && nc < w
                        && close_colors(win_cells[i * 3 + j], win_cells[4]))
                        alone = 1'b0;
                end
            end
            at_end = (cr == h - 1) && (cc == w - 1);
            v.col = 10'(cc);
            v.row = 12'(cr);
            v.outlier = alone;
            v.last = at_end;
            pending_verdicts.push_back(v);
        end
        if (at_end)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        else if (c + 1 >= w)
        begin
            col_pos = '0;
            row_pos = 13'(r + 1);
        end
        else
        begin
            col_pos = 10'(c + 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic pixel_t random_color();
        logic [23:0] raw;
        raw = 24'($urandom);
        return raw;
    endfunction

    function automatic logic [7:0] nudge(logic [7:0] v);
        int t;
        t = int'(v) + int'($urandom_range(0, 24)) - 12;
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return t[7:0];
    endfunction

    // Mostly colors close to a base, some far away
    function automatic pixel_t near_color(pixel_t base);
        pixel_t p;
        if ($urandom_range(0, 9) < 3)
            return random_color();
        p.red   = nudge(base.red);
        p.green = nudge(base.green);
        p.blue  = nudge(base.blue);
        return p;
    endfunction

    function automatic int pick_width();
        if ($urandom_range(0, 19) == 0)
            return 0;
        return $urandom_range(1, 8);
    endfunction

    function automatic int pick_height();
        if ($urandom_range(0, 19) == 0)
            return 0;
        return $urandom_range(1, 6);
    endfunction

    function automatic int pick_threshold();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return 766;
        if (r == 2)
            return 1023;
        if (r == 3)
            return $urandom_range(0, 1023);
        return $urandom_range(1, 80);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------
    task automatic feed(input logic o, input pixel_t p, input bit rush = 1'b0,
                        input bit hold = 1'b0);
        feed_item_t it;
        it.op = o;
        it.px = p;
        it.rush = rush;
        it.hold = hold;
        pixel_feed.push_back(it);
    endtask

    // Wait until the block has nothing in flight
    task automatic settle();
        while (pixel_feed.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_FRAME_WIDTH:
            begin
                cur_width = value[WIDTH_W-1:0];
                col_pos = '0;
                row_pos = '0;
            end
            REG_FRAME_HEIGHT:
            begin
                cur_height = value[HEIGHT_W-1:0];
                col_pos = '0;
                row_pos = '0;
            end
            REG_THRESHOLD:
                cur_thresh = value[THRESH_W-1:0];
            default:
                ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Queue one frame; a cut frame stops early and sends no flush
    task automatic send_frame(input bit cut, input bit rush, input bit hold);
        int     w, h, total, n, k;
        pixel_t base;
        bit     first;
        w = eff_width();
        h = eff_height();
        total = w * h;
        n = (cut && total > 1) ? $urandom_range(1, total - 1) : total;
        base = random_color();
        first = hold;
        for (k = 0; k < n; k++)
        begin
            // early flush, dropped by the block
            if (!rush && $urandom_range(0, 19) == 0)
                feed(OP_FLUSH, random_color(), rush);
            if ($urandom_range(0, 19) == 0)
                base = random_color();
            feed(OP_PIXEL, near_color(base), rush, first);
            first = 1'b0;
            random_items++;
        end
        if (n == total)
        begin
            for (k = 0; k <= w; k++)
            begin
                feed(($urandom_range(0, 4) == 0) ? OP_PIXEL : OP_FLUSH, random_color(), rush);
                random_items++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: take items on the rising edge, present the next on the falling
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            judge_item(op, pixel_t'({red, green, blue}));
            item_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : drive_items
        feed_item_t nxt;
        if (rst_n && (!in_valid || item_taken))
        begin
            if (feed_gap > 0)
            begin
                feed_gap--;
                in_valid <= 1'b0;
            end
            else if (pixel_feed.size() != 0)
            begin
                nxt = pixel_feed.pop_front();
                in_valid <= 1'b1;
                op    <= nxt.op;
                red   <= nxt.px.red;
                green <= nxt.px.green;
                blue  <= nxt.px.blue;
                rush_mode = nxt.rush;
                if (nxt.hold)
                    hold_request = 1'b1;
                feed_gap = nxt.rush ? 0 : pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off to back up the input
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                ready_stall = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (ready_stall > 0)
            begin
                ready_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                ready_stall = rush_mode ? 0 : pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            // keep the log short
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch_results
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none, actual col %0d row %0d",
                             $time, center_col, center_row);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                check_field("center_col", want.col, center_col);
                check_field("center_row", want.row, center_row);
                check_field("is_outlier", want.outlier, is_outlier);
                check_field("frame_last", want.last, frame_last);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : run_sequence
        bit     regeom;
        bit     cut;
        int     k;
        pixel_t base;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 3x2 frame: dropped flushes, color extremes, pixel during flush
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 2);
        write_reg(REG_THRESHOLD, 32);
        feed(OP_FLUSH, pixel_t'(24'h123456));
        feed(OP_PIXEL, pixel_t'(24'h000000));
        feed(OP_PIXEL, pixel_t'(24'h101010));
        feed(OP_PIXEL, pixel_t'(24'h050505));
        feed(OP_FLUSH, pixel_t'(24'hFFFFFF));
        feed(OP_PIXEL, pixel_t'(24'hFFFFFF));
        feed(OP_PIXEL, pixel_t'(24'hF0FFFF));
        feed(OP_PIXEL, pixel_t'(24'h00FF00));
        feed(OP_FLUSH, pixel_t'(24'h000000));
        feed(OP_PIXEL, pixel_t'(24'hABCDEF));
        feed(OP_FLUSH, pixel_t'(24'hFFFFFF));
        feed(OP_FLUSH, pixel_t'(24'h000000));
        settle();

        // single-pixel frame has no neighbor at all
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 1);
        feed(OP_PIXEL, pixel_t'(24'h7F7F7F));
        feed(OP_FLUSH, pixel_t'(24'h000000));
        feed(OP_PIXEL, pixel_t'(24'hFFFFFF));

        // random frames, some cut short by a geometry change
        regeom = 1'b0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (regeom || $urandom_range(0, 9) < 4)
            begin
                settle();
                if (regeom || $urandom_range(0, 1) == 1)
                    write_reg(REG_FRAME_WIDTH, pick_width());
                if (regeom || $urandom_range(0, 1) == 1)
                    write_reg(REG_FRAME_HEIGHT, pick_height());
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_THRESHOLD, pick_threshold());
            end
            cut = ($urandom_range(0, 9) == 0);
            send_frame(cut, $urandom_range(0, 3) == 0, 1'b0);
            regeom = cut;
        end

        // saturated width: the second row starts after the widest row; the
        // receiver holds off once results flow, so the input backs up
        settle();
        write_reg(REG_FRAME_WIDTH, 2047);
        write_reg(REG_FRAME_HEIGHT, 2);
        write_reg(REG_THRESHOLD, pick_threshold());
        base = random_color();
        for (k = 0; k < WIDE_ITEMS; k++)
            feed(OP_PIXEL, near_color(base), 1'b1, k == LINE_DEPTH + 1);

        settle();
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
